[hw/rtl/utf8sd_pkg.sv]
// Package for the UTF-8 stream decoder: field widths, error codes and the result type.
// It has no dependencies. The interfaces and the top level import it.
`timescale 1ns / 1ps

package utf8sd_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned UNIT_W = 32;
   localparam int unsigned ERR_W  = 2;

   localparam logic [15:0]       SURR_HIGH   = 16'hD800;
   localparam logic [15:0]       SURR_LOW    = 16'hDC00;
   localparam logic [UNIT_W-1:0] SUPP_BASE   = 32'h0001_0000;
   localparam logic [UNIT_W-1:0] UTF16_LIMIT = 32'h0011_0000;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE  = 2'd0,
      ERR_LEAD  = 2'd1,
      ERR_CONT  = 2'd2,
      ERR_RANGE = 2'd3
   } err_type;

   typedef struct packed {
      logic [UNIT_W-1:0] unit;
      logic              char_end;
      err_type           error_code;
   } result_type;

endpackage

[hw/rtl/utf8sd_req_if.sv]
// Input channel of the UTF-8 stream decoder: one raw byte per beat.
// It depends on utf8sd_pkg for the field width.
`timescale 1ns / 1ps

interface utf8sd_req_if;
   import utf8sd_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

[hw/rtl/utf8sd_rsp_if.sv]
// Result channel of the UTF-8 stream decoder: one code point or UTF-16 unit per beat.
// It depends on utf8sd_pkg for the field widths.
`timescale 1ns / 1ps

interface utf8sd_rsp_if;
   import utf8sd_pkg::*;

   logic              valid;
   logic              ready;
   logic [UNIT_W-1:0] out_unit;
   logic              char_end;
   logic [ERR_W-1:0]  error_code;

   modport source (output valid, output out_unit, output char_end, output error_code,
                   input ready);
   modport sink   (input valid, input out_unit, input char_end, input error_code,
                   output ready);
endinterface

[hw/rtl/utf8_stream_decoder_unit.sv]
// Streaming UTF-8 decoder with UTF-32 or UTF-16 output and a four-entry result buffer.
// It depends on utf8sd_pkg, utf8sd_req_if and utf8sd_rsp_if.
// A result is written into the result buffer when the byte that completes its character is accepted.
// Throughput: one input byte per cycle; a supplementary character in UTF-16 mode yields
// two result beats, and input stalls only when the result buffer has fewer than two free slots.
// Reset clears the format register, the decoder state and the result buffer.
`timescale 1ns / 1ps

module utf8_stream_decoder_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic                 csr_wr_data,
   utf8sd_req_if.sink           req,
   utf8sd_rsp_if.source         rsp
);
   import utf8sd_pkg::*;

   localparam int unsigned DEPTH = 4;
   localparam int unsigned PTR_W = 2;

   logic             format_ff;
   logic [2:0]       pending_ff;
   logic [2:0]       pending_in;
   logic [31:0]      acc_ff;
   logic [31:0]      acc_in;

   result_type       fifo_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W:0]   count_ff;

   logic             accept;
   logic             pop;
   logic [7:0]       b;
   logic [31:0]      acc_shift;
   logic             emit_valid;
   logic [31:0]      emit_cp;
   logic [19:0]      offset;
   result_type       res0;
   result_type       res1;
   logic [1:0]       push_n;

   assign accept    = req.valid && req.ready;
   assign pop       = rsp.valid && rsp.ready;
   assign b         = req.in_byte;
   assign acc_shift = {acc_ff[25:0], b[5:0]};
   assign offset    = emit_cp[19:0] - SUPP_BASE[19:0];

   assign req.ready      = (count_ff <= (PTR_W+1)'(DEPTH - 2));
   assign rsp.valid      = (count_ff != '0);
   assign rsp.out_unit   = fifo_ff[rd_ptr_ff].unit;
   assign rsp.char_end   = fifo_ff[rd_ptr_ff].char_end;
   assign rsp.error_code = fifo_ff[rd_ptr_ff].error_code;

   always_comb begin
      pending_in = pending_ff;
      acc_in     = acc_ff;
      emit_valid = 1'b0;
      emit_cp    = acc_shift;
      res0       = '{unit: '0, char_end: 1'b1, error_code: ERR_NONE};
      res1       = '{unit: '0, char_end: 1'b1, error_code: ERR_NONE};
      push_n     = 2'd0;

      if (pending_ff != 3'd0) begin
         if (b[7:6] != 2'b10) begin
            pending_in = 3'd0;
            acc_in     = '0;
            res0       = '{unit: '0, char_end: 1'b1, error_code: ERR_CONT};
            push_n     = 2'd1;
         end else begin
            acc_in     = acc_shift;
            pending_in = pending_ff - 3'd1;
            if (pending_ff == 3'd1) begin
               acc_in     = '0;
               emit_valid = 1'b1;
            end
         end
      end else begin
         priority if (b[7] == 1'b0) begin
            emit_valid = 1'b1;
            emit_cp    = {24'd0, b};
         end else if (b[7:5] == 3'b110) begin
            pending_in = 3'd1;
            acc_in     = {27'd0, b[4:0]};
         end else if (b[7:4] == 4'b1110) begin
            pending_in = 3'd2;
            acc_in     = {28'd0, b[3:0]};
         end else if (b[7:3] == 5'b11110) begin
            pending_in = 3'd3;
            acc_in     = {29'd0, b[2:0]};
         end else if (b[7:2] == 6'b111110) begin
            pending_in = 3'd4;
            acc_in     = {30'd0, b[1:0]};
         end else if (b[7:1] == 7'b1111110) begin
            pending_in = 3'd5;
            acc_in     = {31'd0, b[0]};
         end else if (b == 8'hFE) begin
            pending_in = 3'd6;
            acc_in     = '0;
         end else begin
            acc_in = '0;
            res0   = '{unit: '0, char_end: 1'b1, error_code: ERR_LEAD};
            push_n = 2'd1;
         end
      end

      if (emit_valid) begin
         push_n = 2'd1;
         if (!format_ff || emit_cp < SUPP_BASE) begin
            res0 = '{unit: emit_cp, char_end: 1'b1, error_code: ERR_NONE};
         end else if (emit_cp < UTF16_LIMIT) begin
            res0   = '{unit: {16'd0, SURR_HIGH | {6'd0, offset[19:10]}},
                       char_end: 1'b0, error_code: ERR_NONE};
            res1   = '{unit: {16'd0, SURR_LOW | {6'd0, offset[9:0]}},
                       char_end: 1'b1, error_code: ERR_NONE};
            push_n = 2'd2;
         end else begin
            res0 = '{unit: '0, char_end: 1'b1, error_code: ERR_RANGE};
         end
      end

      if (!accept) begin
         pending_in = pending_ff;
         acc_in     = acc_ff;
         push_n     = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff  <= 1'b0;
         pending_ff <= 3'd0;
         acc_ff     <= '0;
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         count_ff   <= '0;
      end else begin
         if (csr_wr_en) begin
            format_ff <= csr_wr_data;
         end
         pending_ff <= pending_in;
         acc_ff     <= acc_in;
         wr_ptr_ff  <= wr_ptr_ff + PTR_W'(push_n);
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         count_ff <= count_ff + (PTR_W+1)'(push_n) - (PTR_W+1)'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= res0;
      end
      if (push_n == 2'd2) begin
         fifo_ff[wr_ptr_ff + PTR_W'(1)] <= res1;
      end
   end

endmodule
